>>> hw/rtl/glyph_bitmap_similarity_matcher_unit_macros.svh
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef GLYPH_BITMAP_SIMILARITY_MATCHER_UNIT_MACROS_SVH
`define GLYPH_BITMAP_SIMILARITY_MATCHER_UNIT_MACROS_SVH

`ifndef SYNTH
`define GBSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbsm: same-cycle check failed");
`define GBSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbsm: next-cycle check failed");
`else
`define GBSM_ASSERT_IMP(lbl, ante, cons)
`define GBSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/gbsm_pkg.sv
package gbsm_pkg;

    localparam int CNT_W   = 12;
    localparam int SCORE_W = 17;
    localparam int CODE_W  = 21;
    localparam int DEN_W   = 24;

    localparam logic [CNT_W-1:0]   COUNT_MAX    = 12'hFFF;
    localparam logic [SCORE_W-1:0] ONE_Q16      = 17'd65536;
    localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd52429;

    typedef struct packed {
        logic [7:0]        ref_byte;
        logic [7:0]        glyph_byte;
        logic [CODE_W-1:0] glyph_code;
        logic              glyph_end;
        logic              list_end;
    } in_word_t;

    typedef struct packed {
        logic [SCORE_W-1:0] glyph_score;
        logic [CODE_W-1:0]  best_code;
        logic [SCORE_W-1:0] best_score;
        logic               search_done;
    } out_word_t;

    // one finished glyph, handed from the counting front to the scoring back
    typedef struct packed {
        logic [CNT_W-1:0]  union_cnt;
        logic [CNT_W-1:0]  overlap_cnt;
        logic [CNT_W-1:0]  noise_cnt;
        logic [CODE_W-1:0] code;
        logic              list_end;
    } job_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc,
                                                 input logic [3:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, acc} + {{(CNT_W-3){1'b0}}, inc};
        return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/gbsm_front.sv
module gbsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gbsm_pkg::in_word_t in_word,
    input  logic              q_full,
    output logic              push,
    output gbsm_pkg::job_t    job
);

    logic [gbsm_pkg::CNT_W-1:0] union_reg, overlap_reg, noise_reg;
    logic [gbsm_pkg::CNT_W-1:0] union_next, overlap_next, noise_next;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        union_next   = gbsm_pkg::sat_add(union_reg,
                           gbsm_pkg::popcount8(in_word.ref_byte | in_word.glyph_byte));
        overlap_next = gbsm_pkg::sat_add(overlap_reg,
                           gbsm_pkg::popcount8(in_word.ref_byte & in_word.glyph_byte));
        noise_next   = gbsm_pkg::sat_add(noise_reg,
                           gbsm_pkg::popcount8(in_word.glyph_byte & ~in_word.ref_byte));
    end

    // bytes of a settled list are counted too; the back drops those glyphs
    assign push            = accept && in_word.glyph_end;
    assign job.union_cnt   = union_next;
    assign job.overlap_cnt = overlap_next;
    assign job.noise_cnt   = noise_next;
    assign job.code        = in_word.glyph_code;
    assign job.list_end    = in_word.list_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            union_reg   <= '0;
            overlap_reg <= '0;
            noise_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_word.glyph_end)
            begin
                union_reg   <= '0;
                overlap_reg <= '0;
                noise_reg   <= '0;
            end
            else
            begin
                union_reg   <= union_next;
                overlap_reg <= overlap_next;
                noise_reg   <= noise_next;
            end
        end
    end

endmodule

>>> hw/rtl/gbsm_queue.sv
`include "glyph_bitmap_similarity_matcher_unit_macros.svh"

module gbsm_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gbsm_pkg::job_t push_job,
    input  logic           pop,
    output gbsm_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    gbsm_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_job = mem[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `GBSM_ASSERT_IMP(a_no_overflow, push && !pop, count_reg != FULL_CNT)
    `GBSM_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)
    `GBSM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> hw/rtl/gbsm_back.sv
`include "glyph_bitmap_similarity_matcher_unit_macros.svh"

module gbsm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gbsm_pkg::SCORE_W-1:0]      cfg_wdata,
    input  gbsm_pkg::job_t                    head_job,
    input  logic                              q_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output gbsm_pkg::out_word_t               out_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam int STEP_W = $clog2(gbsm_pkg::SCORE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(gbsm_pkg::SCORE_W - 1);

    state_t                          state_reg;
    gbsm_pkg::job_t                  job_reg;
    logic [gbsm_pkg::DEN_W-1:0]      den_reg, rem_reg;
    logic [gbsm_pkg::SCORE_W-1:0]    quo_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [gbsm_pkg::SCORE_W-1:0]    thr_reg, best_sim_reg;
    logic [gbsm_pkg::CODE_W-1:0]     best_code_reg;
    logic                            settled_reg;
    logic                            out_valid_reg;
    gbsm_pkg::out_word_t             out_reg;

    logic [gbsm_pkg::DEN_W:0]        shifted;
    logic                            ge;
    logic [gbsm_pkg::DEN_W-1:0]      rem_next;
    logic [gbsm_pkg::DEN_W-1:0]      den_next;
    logic                            upd, settled_next, load_out;
    logic [gbsm_pkg::SCORE_W-1:0]    best_sim_next;
    logic [gbsm_pkg::CODE_W-1:0]     best_code_next;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[gbsm_pkg::SCORE_W-1]};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? gbsm_pkg::DEN_W'(shifted - {1'b0, den_reg})
                      : shifted[gbsm_pkg::DEN_W-1:0];
    end

    always_comb
    begin
        den_next = {{(gbsm_pkg::DEN_W-gbsm_pkg::CNT_W){1'b0}}, job_reg.union_cnt}
                 + (gbsm_pkg::DEN_W'(job_reg.noise_cnt) * gbsm_pkg::DEN_W'(job_reg.noise_cnt));
    end

    always_comb
    begin
        upd            = (quo_reg >= best_sim_reg);
        best_sim_next  = upd ? quo_reg : best_sim_reg;
        best_code_next = upd ? job_reg.code : best_code_reg;
        settled_next   = settled_reg || (upd && (quo_reg >= thr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= gbsm_pkg::THRESH_RESET;
            best_sim_reg  <= '0;
            best_code_reg <= '0;
            settled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        if (settled_reg)
                        begin
                            // settled list: drop the glyph, reset on list end
                            if (head_job.list_end)
                            begin
                                best_sim_reg  <= '0;
                                best_code_reg <= '0;
                                settled_reg   <= 1'b0;
                            end
                        end
                        else if (head_job.union_cnt == '0)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (job_reg.list_end)
                        begin
                            best_sim_reg  <= '0;
                            best_code_reg <= '0;
                            settled_reg   <= 1'b0;
                        end
                        else
                        begin
                            best_sim_reg  <= best_sim_next;
                            best_code_reg <= best_code_next;
                            settled_reg   <= settled_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_reg <= head_job;
                    quo_reg <= gbsm_pkg::ONE_Q16;
                end
            end
            ST_MUL:
            begin
                den_reg  <= den_next;
                // quotient fits 17 bits, so the top 11 dividend bits seed the remainder
                rem_reg  <= gbsm_pkg::DEN_W'(job_reg.overlap_cnt[gbsm_pkg::CNT_W-1:1]);
                quo_reg  <= {job_reg.overlap_cnt[0], 16'h0000};
                step_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[gbsm_pkg::SCORE_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    out_reg.glyph_score <= quo_reg;
                    out_reg.best_code   <= best_code_next;
                    out_reg.best_score  <= best_sim_next;
                    out_reg.search_done <= settled_next || job_reg.list_end;
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
    end

    `GBSM_ASSERT_IMP(a_rem_below_den, state_reg == ST_DIV, rem_reg < den_reg)
    `GBSM_ASSERT_IMP(a_best_covers_score, out_valid_reg, out_reg.best_score >= out_reg.glyph_score)
    `GBSM_ASSERT_NEXT(a_list_cleared, load_out && job_reg.list_end, !settled_reg && best_sim_reg == '0)

endmodule

>>> hw/rtl/glyph_bitmap_similarity_matcher_unit.sv
// Takes one byte pair word per cycle unless the queue is full; a queue of QUEUE_DEPTH finished
// glyphs sits before scoring. Scoring a glyph steps through pop, 12x12 square, 17-step divider
// and result, or pop and result only when the union is empty; the serial divider sets glyph
// throughput and the scorer takes one glyph at a time, so input stalls once the queue fills.
// Glyphs of a settled list are dropped without scoring.
// rst_n clears counts, best score, settled flag and queue; threshold resets to 52429.
module glyph_bitmap_similarity_matcher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  gbsm_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output gbsm_pkg::out_word_t           out_word,
    input  logic                          cfg_we,
    input  logic [gbsm_pkg::SCORE_W-1:0]  cfg_wdata
);

    logic           push, pop, q_full, q_empty;
    gbsm_pkg::job_t push_job, head_job;

    gbsm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job)
    );

    gbsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    gbsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head_job  (head_job),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

>>> dv/glyph_score_checker.sv
module glyph_score_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  gbsm_pkg::in_word_t            in_word,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  gbsm_pkg::out_word_t           out_word,
    input  logic                          cfg_we,
    input  logic [gbsm_pkg::SCORE_W-1:0]  cfg_wdata,
    output int unsigned                   fails,
    output int unsigned                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [gbsm_pkg::CNT_W-1:0]   union_cnt;
    logic [gbsm_pkg::CNT_W-1:0]   overlap_cnt;
    logic [gbsm_pkg::CNT_W-1:0]   noise_cnt;
    logic [gbsm_pkg::SCORE_W-1:0] best_sim;
    logic [gbsm_pkg::CODE_W-1:0]  best_code;
    logic                         settled;
    logic [gbsm_pkg::SCORE_W-1:0] threshold;
    gbsm_pkg::out_word_t          expected_scores[$];
    int unsigned                  fail_tally;

    function automatic logic [gbsm_pkg::CNT_W-1:0] saturating_sum(
        input logic [gbsm_pkg::CNT_W-1:0] acc,
        input logic [7:0] pixels);
        logic [gbsm_pkg::CNT_W:0] s;
        s = {1'b0, acc} + (gbsm_pkg::CNT_W+1)'($countones(pixels));
        return (s > gbsm_pkg::COUNT_MAX) ? gbsm_pkg::COUNT_MAX : s[gbsm_pkg::CNT_W-1:0];
    endfunction

    // overlap / (union + noise^2) in Q1.16, truncated; empty union scores 1.0
    function automatic logic [gbsm_pkg::SCORE_W-1:0] glyph_similarity(
        input logic [gbsm_pkg::CNT_W-1:0] u,
        input logic [gbsm_pkg::CNT_W-1:0] o,
        input logic [gbsm_pkg::CNT_W-1:0] n);
        logic [gbsm_pkg::DEN_W:0]     den;
        logic [gbsm_pkg::CNT_W+15:0]  num;
        logic [gbsm_pkg::CNT_W+15:0]  quo;
        if (u == '0)
            return gbsm_pkg::ONE_Q16;
        den = u + n * n;
        num = {o, 16'h0000};
        quo = num / den;
        return quo[gbsm_pkg::SCORE_W-1:0];
    endfunction

    function automatic void clear_list();
        union_cnt   = '0;
        overlap_cnt = '0;
        noise_cnt   = '0;
        best_sim    = '0;
        best_code   = '0;
        settled     = 1'b0;
    endfunction

    function automatic void predict_word(input gbsm_pkg::in_word_t w);
        logic [gbsm_pkg::SCORE_W-1:0] score;
        gbsm_pkg::out_word_t          res;
        // a settled list swallows words until its closing glyph_end
        if (settled)
        begin
            if (w.glyph_end && w.list_end)
                clear_list();
            return;
        end
        union_cnt   = saturating_sum(union_cnt, w.ref_byte | w.glyph_byte);
        overlap_cnt = saturating_sum(overlap_cnt, w.ref_byte & w.glyph_byte);
        noise_cnt   = saturating_sum(noise_cnt, w.glyph_byte & ~w.ref_byte);
        if (!w.glyph_end)
            return;
        score       = glyph_similarity(union_cnt, overlap_cnt, noise_cnt);
        union_cnt   = '0;
        overlap_cnt = '0;
        noise_cnt   = '0;
        // ties go to the later glyph
        if (score >= best_sim)
        begin
            best_sim  = score;
            best_code = w.glyph_code;
            if (score >= threshold)
                settled = 1'b1;
        end
        res.glyph_score = score;
        res.best_code   = best_code;
        res.best_score  = best_sim;
        res.search_done = settled || w.list_end;
        expected_scores.push_back(res);
        if (w.list_end)
            clear_list();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gbsm_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            clear_list();
            threshold = gbsm_pkg::THRESH_RESET;
            expected_scores.delete();
            fail_tally = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("result word with none expected: glyph_score %0d best_code %0d",
                           out_word.glyph_score, out_word.best_code);
                    fail_tally++;
                end
                else
                begin
                    exp_w = expected_scores.pop_front();
                    if (out_word.glyph_score !== exp_w.glyph_score)
                    begin
                        $error("glyph_score: expected %0d, got %0d",
                               exp_w.glyph_score, out_word.glyph_score);
                        fail_tally++;
                    end
                    if (out_word.best_code !== exp_w.best_code)
                    begin
                        $error("best_code: expected %0d, got %0d",
                               exp_w.best_code, out_word.best_code);
                        fail_tally++;
                    end
                    if (out_word.best_score !== exp_w.best_score)
                    begin
                        $error("best_score: expected %0d, got %0d",
                               exp_w.best_score, out_word.best_score);
                        fail_tally++;
                    end
                    if (out_word.search_done !== exp_w.search_done)
                    begin
                        $error("search_done: expected %0d, got %0d",
                               exp_w.search_done, out_word.search_done);
                        fail_tally++;
                    end
                end
            end
            if (cfg_we)
                threshold = cfg_wdata;
            if (in_valid && !in_stall)
                predict_word(in_word);
            fails   <= fail_tally;
            pending <= expected_scores.size();
        end
    end

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS  = 400;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam logic [gbsm_pkg::CODE_W-1:0] CODE_TOP = 21'd1114111;

    typedef enum {
        MIX_RANDOM,
        MIX_MATCH,
        MIX_NEAR,
        MIX_BLANK,
        MIX_STRAY,
        MIX_FULL,
        MIX_STRAY_FULL
    } pixel_mix_e;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    gbsm_pkg::in_word_t            in_word;
    logic                          out_valid;
    logic                          out_stall;
    gbsm_pkg::out_word_t           out_word;
    logic                          cfg_we;
    logic [gbsm_pkg::SCORE_W-1:0]  cfg_wdata;

    int unsigned         fails;
    int unsigned         pending;
    int unsigned         cycles = 0;
    int unsigned         words_sent = 0;
    bit                  calm = 1'b0;

    glyph_bitmap_similarity_matcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    glyph_score_checker score_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL glyph_bitmap_similarity_matcher_unit");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 33);

    function automatic gbsm_pkg::in_word_t make_word(input logic [7:0] r, input logic [7:0] g,
                                                     input logic [gbsm_pkg::CODE_W-1:0] code,
                                                     input logic gend, input logic lend);
        gbsm_pkg::in_word_t w;
        w.ref_byte   = r;
        w.glyph_byte = g;
        w.glyph_code = code;
        w.glyph_end  = gend;
        w.list_end   = lend;
        return w;
    endfunction

    function automatic logic [gbsm_pkg::CODE_W-1:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CODE_TOP;
            default: return gbsm_pkg::CODE_W'($urandom_range(0, CODE_TOP));
        endcase
    endfunction

    task automatic send_word(input gbsm_pkg::in_word_t w);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // a glyph_end with no result may still be in the scorer when the queue runs dry
    task automatic set_threshold(input logic [gbsm_pkg::SCORE_W-1:0] thr);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_glyph(input int unsigned len, input pixel_mix_e mix,
                              input logic [gbsm_pkg::CODE_W-1:0] code, input bit closes_list);
        logic [7:0]         r;
        logic [7:0]         g;
        gbsm_pkg::in_word_t w;
        for (int unsigned i = 0; i < len; i++)
        begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            case (mix)
                MIX_MATCH:      g = r;
                MIX_NEAR:       g = ($urandom_range(0, 2) == 0) ?
                                    r ^ (8'h01 << $urandom_range(0, 7)) : r;
                MIX_BLANK:
                begin
                    r = 8'h00;
                    g = 8'h00;
                end
                MIX_STRAY:      r = 8'h00;
                MIX_FULL:
                begin
                    r = 8'hFF;
                    g = 8'hFF;
                end
                MIX_STRAY_FULL:
                begin
                    r = 8'h00;
                    g = 8'hFF;
                end
                default:        ;
            endcase
            w = make_word(r, g, code, i == len - 1, closes_list);
            // list_end and code only count on the glyph_end word
            if (i != len - 1 && $urandom_range(0, 19) == 0)
            begin
                w.list_end   = !closes_list;
                w.glyph_code = pick_code();
            end
            send_word(w);
        end
    endtask

    task automatic send_list(input int unsigned glyphs);
        int unsigned len;
        for (int unsigned k = 0; k < glyphs; k++)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            send_glyph(len, pixel_mix_e'($urandom_range(0, 4)), pick_code(), k == glyphs - 1);
        end
    endtask

    initial
    begin
        logic [gbsm_pkg::SCORE_W-1:0] thresholds[PHASES];
        int unsigned                  phase_mark;

        thresholds = '{gbsm_pkg::THRESH_RESET, '0, gbsm_pkg::ONE_Q16, 17'h1FFFF, 17'd65535,
                       17'd1, gbsm_pkg::THRESH_RESET};
        thresholds[5] = gbsm_pkg::SCORE_W'($urandom_range(1, 65535));

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full match settles at once; the rest of that list is swallowed
        send_word(make_word(8'hFF, 8'hFF, CODE_TOP, 1'b1, 1'b0));
        send_word(make_word(8'h00, 8'hFF, 21'd5, 1'b0, 1'b0));
        send_word(make_word(8'h12, 8'h34, 21'd5, 1'b1, 1'b0));
        send_word(make_word(8'h00, 8'h00, 21'd5, 1'b1, 1'b1));
        // zero score still takes the best slot, stray list_end mid-glyph
        send_word(make_word(8'h00, 8'hFF, 21'd0, 1'b1, 1'b0));
        send_word(make_word(8'hFF, 8'h00, 21'd100, 1'b0, 1'b1));
        send_word(make_word(8'hF0, 8'hFF, 21'd100, 1'b1, 1'b0));
        send_word(make_word(8'hAA, 8'hAA, 21'd7, 1'b0, 1'b0));
        send_word(make_word(8'h55, 8'h54, 21'd7, 1'b1, 1'b0));
        send_word(make_word(8'hFF, 8'hFF, 21'd9, 1'b1, 1'b1));
        // empty union on the closing glyph
        send_word(make_word(8'h00, 8'h00, 21'd3, 1'b0, 1'b1));
        send_word(make_word(8'h00, 8'h00, 21'd3, 1'b1, 1'b1));
        // list ends below threshold
        send_word(make_word(8'h81, 8'hC3, CODE_TOP, 1'b1, 1'b0));
        send_word(make_word(8'h0F, 8'h1F, 21'h10000, 1'b1, 1'b1));

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            if (p != 0)
                set_threshold(thresholds[p]);
            calm = (p == 2) || (p == 3);
            if (p == 3)
            begin
                // counts saturate; threshold out of reach so both score
                send_glyph(514, MIX_FULL, pick_code(), 1'b0);
                send_glyph(514, MIX_STRAY_FULL, pick_code(), 1'b1);
            end
            phase_mark = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < phase_mark)
            begin
                send_list($urandom_range(1, 6));
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("PASS glyph_bitmap_similarity_matcher_unit");
        else
            $display("FAIL glyph_bitmap_similarity_matcher_unit");
        $finish;
    end

endmodule

>>> glyph_bitmap_similarity_matcher_unit.f
+incdir+hw/rtl
hw/rtl/gbsm_pkg.sv
hw/rtl/gbsm_front.sv
hw/rtl/gbsm_queue.sv
hw/rtl/gbsm_back.sv
hw/rtl/glyph_bitmap_similarity_matcher_unit.sv
dv/glyph_score_checker.sv
dv/tb.sv
